// ===== rtl/pfc_pkg.sv =====
// pfc_pkg: shared types, codes and helpers for the pixel format converter
// depends on nothing; imported by every other file of the block

package pfc_pkg;

    localparam int PIXEL_W = 64;
    localparam int WORD_W  = 32;
    localparam int NBYTES_W = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SOURCE_ENCODING   = 2'd0;
    localparam logic [1:0] REG_SOURCE_BIG_ENDIAN = 2'd1;
    localparam logic [1:0] REG_OUTPUT_FORMAT     = 2'd2;

    // source encodings
    localparam logic [3:0] SRC_RGB8   = 4'd0;
    localparam logic [3:0] SRC_BGR8   = 4'd1;
    localparam logic [3:0] SRC_MONO8  = 4'd2;
    localparam logic [3:0] SRC_MONO16 = 4'd3;
    localparam logic [3:0] SRC_RGB16  = 4'd4;
    localparam logic [3:0] SRC_BGR16  = 4'd5;
    localparam logic [3:0] SRC_RGBA8  = 4'd6;
    localparam logic [3:0] SRC_BGRA8  = 4'd7;
    localparam logic [3:0] SRC_RGBA16 = 4'd8;
    localparam logic [3:0] SRC_BGRA16 = 4'd9;

    // output formats
    localparam logic [3:0] FMT_RGB24      = 4'd0;
    localparam logic [3:0] FMT_BGR24      = 4'd1;
    localparam logic [3:0] FMT_RGB32      = 4'd2;
    localparam logic [3:0] FMT_BGR32      = 4'd3;
    localparam logic [3:0] FMT_ARGB32     = 4'd4;
    localparam logic [3:0] FMT_BGRA32     = 4'd5;
    localparam logic [3:0] FMT_ARGB32_PM  = 4'd6;
    localparam logic [3:0] FMT_BGRA32_PM  = 4'd7;
    localparam logic [3:0] FMT_Y8         = 4'd8;
    localparam logic [3:0] FMT_Y16        = 4'd9;

    localparam logic [NBYTES_W-1:0] NB_Y8   = 3'd1;
    localparam logic [NBYTES_W-1:0] NB_Y16  = 3'd2;
    localparam logic [NBYTES_W-1:0] NB_RGB  = 3'd3;
    localparam logic [NBYTES_W-1:0] NB_WORD = 3'd4;

    localparam logic [7:0] OPAQUE = 8'd255;

    // luma weights, Q0.16 (0.299, 0.587, 0.114)
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    typedef struct packed {
        logic [3:0] source_encoding;
        logic       source_big_endian;
        logic [3:0] output_format;
    } cfg_t;

    // stage 1 result: channels picked out of the source bytes
    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] lr;
        logic [15:0] lg;
        logic [15:0] lb;
        logic        luma_wide;
    } chan_t;

    // stage 2 result: products
    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        logic [31:0] yr;
        logic [31:0] yg;
        logic [31:0] yb;
        logic        luma_wide;
    } prod_t;

    // stage 3 result: everything the packer can choose from
    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [7:0]  qr;
        logic [7:0]  qg;
        logic [7:0]  qb;
        logic [15:0] luma;
    } res_t;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

// ===== rtl/pfc_if.sv =====
// pfc_if: valid/ready channel interfaces for source pixels and packed results
// depends on pfc_pkg

interface pfc_in_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_bytes;

    modport source (output valid, output pixel_bytes, input ready);
    modport sink (input valid, input pixel_bytes, output ready);
endinterface

interface pfc_out_if;
    import pfc_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   out_word;
    logic [NBYTES_W-1:0] out_bytes;

    modport source (output valid, output out_word, output out_bytes, input ready);
    modport sink (input valid, input out_word, input out_bytes, output ready);
endinterface

// ===== rtl/pixel_format_converter_unit.sv =====
// pixel_format_converter_unit: top level of the pixel format converter
// depends on pfc_pkg, pfc_if, pfc_cfg, pfc_unpack, pfc_arith, pfc_pack
//
// usage:
//  - pix_in carries one raw source pixel per request in pixel_bytes
//    (first stream byte in bits 7:0); pix_out returns one packed pixel
//    per request in out_word with its byte count in out_bytes
//  - the APB port sets source_encoding (0x0), source_big_endian (0x4) and
//    output_format (0x8); write them only while the pipeline is empty
//  - four register stages: unpack, multiply, luma sum / divide by 255,
//    output pack, passed through in that order on the way to pix_out;
//    one request per cycle is taken when pix_out keeps up
//  - every stage holds its own valid bit, so bubbles close up and a stage
//    takes a new request while the next one still holds a result
//  - when the receiver stalls, data holds in place and pix_in.ready drops
//    once all four stages are full; nothing is dropped or repeated
//  - reset empties the pipeline and clears the configuration registers to
//    zero (rgb8 source, little endian, rgb24 output)

module pixel_format_converter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pfc_pkg::DATA_W-1:0]  pwdata,
    output logic [pfc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    pfc_in_if.sink                      pix_in,
    pfc_out_if.source                   pix_out
);
    import pfc_pkg::*;

    cfg_t  cfg;
    logic  unp_valid;
    logic  unp_ready;
    chan_t unp_chan;
    logic  ari_valid;
    logic  ari_ready;
    res_t  ari_res;

    pfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfc_unpack u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (pix_in.valid),
        .in_ready    (pix_in.ready),
        .pixel_bytes (pix_in.pixel_bytes),
        .out_valid   (unp_valid),
        .out_ready   (unp_ready),
        .out_chan    (unp_chan)
    );

    pfc_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (unp_valid),
        .in_ready  (unp_ready),
        .in_chan   (unp_chan),
        .out_valid (ari_valid),
        .out_ready (ari_ready),
        .out_res   (ari_res)
    );

    pfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (ari_valid),
        .in_ready  (ari_ready),
        .in_res    (ari_res),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_word  (pix_out.out_word),
        .out_bytes (pix_out.out_bytes)
    );

endmodule

// ===== rtl/pfc_cfg.sv =====
// pfc_cfg: APB register file holding source encoding, endianness, output format
// depends on pfc_pkg

module pfc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfc_pkg::ADDR_W-1:0]    paddr,
    input  logic [pfc_pkg::DATA_W-1:0]    pwdata,
    output logic [pfc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output pfc_pkg::cfg_t                 cfg
);
    import pfc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SOURCE_ENCODING:   cfg_next.source_encoding = pwdata[3:0];
                REG_SOURCE_BIG_ENDIAN: cfg_next.source_big_endian = pwdata[0];
                REG_OUTPUT_FORMAT:     cfg_next.output_format = pwdata[3:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_ENCODING:   prdata = {28'd0, cfg_reg.source_encoding};
            REG_SOURCE_BIG_ENDIAN: prdata = {31'd0, cfg_reg.source_big_endian};
            REG_OUTPUT_FORMAT:     prdata = {28'd0, cfg_reg.output_format};
            default:               prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pfc_unpack.sv =====
// pfc_unpack: pipeline stage 1, picks the channels out of the raw source bytes
// depends on pfc_pkg

module pfc_unpack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfc_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pfc_pkg::PIXEL_W-1:0]  pixel_bytes,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pfc_pkg::chan_t               out_chan
);
    import pfc_pkg::*;

    function automatic logic [7:0] get_byte(input logic [PIXEL_W-1:0] px,
                                            input logic [2:0] k);
        return px[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [15:0] get_sample(input logic [PIXEL_W-1:0] px,
                                               input logic [1:0] c,
                                               input logic big_endian);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = px[{c, 4'b0000} +: 8];
        hi = px[{c, 4'b1000} +: 8];
        return big_endian ? {lo, hi} : {hi, lo};
    endfunction

    logic       valid_reg;
    logic       valid_next;
    chan_t      chan_reg;
    chan_t      chan_next;
    logic [1:0] ri;
    logic [1:0] gi;
    logic [1:0] bi;
    logic       wide;
    logic       has_alpha;
    logic [15:0] r16;
    logic [15:0] g16;
    logic [15:0] b16;
    logic [15:0] a16;

    always_comb
    begin
        ri = 2'd0;
        gi = 2'd1;
        bi = 2'd2;
        wide = 1'b0;
        has_alpha = 1'b0;
        case (cfg.source_encoding)
            SRC_BGR8:
            begin
                ri = 2'd2;
                bi = 2'd0;
            end
            SRC_MONO8:
            begin
                gi = 2'd0;
                bi = 2'd0;
            end
            SRC_MONO16:
            begin
                gi = 2'd0;
                bi = 2'd0;
                wide = 1'b1;
            end
            SRC_RGB16:
            begin
                wide = 1'b1;
            end
            SRC_BGR16:
            begin
                ri = 2'd2;
                bi = 2'd0;
                wide = 1'b1;
            end
            SRC_RGBA8:
            begin
                has_alpha = 1'b1;
            end
            SRC_BGRA8:
            begin
                ri = 2'd2;
                bi = 2'd0;
                has_alpha = 1'b1;
            end
            SRC_RGBA16:
            begin
                wide = 1'b1;
                has_alpha = 1'b1;
            end
            SRC_BGRA16:
            begin
                ri = 2'd2;
                bi = 2'd0;
                wide = 1'b1;
                has_alpha = 1'b1;
            end
            default:
            begin
                ri = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        r16 = get_sample(pixel_bytes, ri, cfg.source_big_endian);
        g16 = get_sample(pixel_bytes, gi, cfg.source_big_endian);
        b16 = get_sample(pixel_bytes, bi, cfg.source_big_endian);
        a16 = get_sample(pixel_bytes, 2'd3, cfg.source_big_endian);

        chan_next = '0;
        if (wide)
        begin
            chan_next.r = r16[15:8];
            chan_next.g = g16[15:8];
            chan_next.b = b16[15:8];
            chan_next.a = has_alpha ? a16[15:8] : OPAQUE;
        end
        else
        begin
            chan_next.r = get_byte(pixel_bytes, {1'b0, ri});
            chan_next.g = get_byte(pixel_bytes, {1'b0, gi});
            chan_next.b = get_byte(pixel_bytes, {1'b0, bi});
            chan_next.a = has_alpha ? get_byte(pixel_bytes, 3'd3) : OPAQUE;
        end

        // y16 from a 16-bit source works on the full samples
        chan_next.luma_wide = wide && (cfg.output_format == FMT_Y16);
        chan_next.lr = chan_next.luma_wide ? r16 : {8'd0, chan_next.r};
        chan_next.lg = chan_next.luma_wide ? g16 : {8'd0, chan_next.g};
        chan_next.lb = chan_next.luma_wide ? b16 : {8'd0, chan_next.b};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            chan_reg <= chan_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_chan  = chan_reg;

endmodule

// ===== rtl/pfc_arith.sv =====
// pfc_arith: pipeline stages 2 and 3, luma and premultiply products, then
// the luma sum and the divide by 255; depends on pfc_pkg

module pfc_arith (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfc_pkg::chan_t  in_chan,
    output logic            out_valid,
    input  logic            out_ready,
    output pfc_pkg::res_t   out_res
);
    import pfc_pkg::*;

    logic  mul_valid_reg;
    logic  mul_valid_next;
    logic  mul_ready;
    prod_t prod_reg;
    prod_t prod_next;

    logic  sum_valid_reg;
    logic  sum_valid_next;
    logic  sum_ready;
    res_t  res_reg;
    res_t  res_next;
    logic [31:0] luma_sum;

    // stage 2: multipliers
    always_comb
    begin
        prod_next.r  = in_chan.r;
        prod_next.g  = in_chan.g;
        prod_next.b  = in_chan.b;
        prod_next.a  = in_chan.a;
        prod_next.pr = {8'd0, in_chan.a} * {8'd0, in_chan.r};
        prod_next.pg = {8'd0, in_chan.a} * {8'd0, in_chan.g};
        prod_next.pb = {8'd0, in_chan.a} * {8'd0, in_chan.b};
        prod_next.yr = {16'd0, LUMA_WR} * {16'd0, in_chan.lr};
        prod_next.yg = {16'd0, LUMA_WG} * {16'd0, in_chan.lg};
        prod_next.yb = {16'd0, LUMA_WB} * {16'd0, in_chan.lb};
        prod_next.luma_wide = in_chan.luma_wide;
    end

    assign mul_ready      = !mul_valid_reg || sum_ready;
    assign in_ready       = mul_ready;
    assign mul_valid_next = mul_ready ? in_valid : mul_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    // stage 3: luma sum stays below 2^32 since the weights add to 65536
    assign luma_sum = prod_reg.yr + prod_reg.yg + prod_reg.yb;

    always_comb
    begin
        res_next.r    = prod_reg.r;
        res_next.g    = prod_reg.g;
        res_next.b    = prod_reg.b;
        res_next.a    = prod_reg.a;
        res_next.qr   = div255(prod_reg.pr);
        res_next.qg   = div255(prod_reg.pg);
        res_next.qb   = div255(prod_reg.pb);
        res_next.luma = prod_reg.luma_wide ? luma_sum[31:16] : luma_sum[23:8];
    end

    assign sum_ready      = !sum_valid_reg || out_ready;
    assign sum_valid_next = sum_ready ? mul_valid_reg : sum_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && mul_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/pfc_pack.sv =====
// pfc_pack: pipeline stage 4, packs the output word by format into the
// output register; depends on pfc_pkg

module pfc_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pfc_pkg::res_t                 in_res,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfc_pkg::WORD_W-1:0]    out_word,
    output logic [pfc_pkg::NBYTES_W-1:0]  out_bytes
);
    import pfc_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic [NBYTES_W-1:0] nbytes_reg;
    logic [NBYTES_W-1:0] nbytes_next;

    always_comb
    begin
        case (cfg.output_format)
            FMT_BGR24:
            begin
                word_next   = {8'd0, in_res.r, in_res.g, in_res.b};
                nbytes_next = NB_RGB;
            end
            FMT_RGB32:
            begin
                word_next   = {OPAQUE, in_res.r, in_res.g, in_res.b};
                nbytes_next = NB_WORD;
            end
            FMT_BGR32:
            begin
                word_next   = {OPAQUE, in_res.b, in_res.g, in_res.r};
                nbytes_next = NB_WORD;
            end
            FMT_ARGB32:
            begin
                word_next   = {in_res.a, in_res.r, in_res.g, in_res.b};
                nbytes_next = NB_WORD;
            end
            FMT_BGRA32:
            begin
                word_next   = {in_res.a, in_res.b, in_res.g, in_res.r};
                nbytes_next = NB_WORD;
            end
            FMT_ARGB32_PM:
            begin
                word_next   = {in_res.a, in_res.qr, in_res.qg, in_res.qb};
                nbytes_next = NB_WORD;
            end
            FMT_BGRA32_PM:
            begin
                word_next   = {in_res.a, in_res.qb, in_res.qg, in_res.qr};
                nbytes_next = NB_WORD;
            end
            FMT_Y8:
            begin
                word_next   = {24'd0, in_res.luma[15:8]};
                nbytes_next = NB_Y8;
            end
            FMT_Y16:
            begin
                word_next   = {16'd0, in_res.luma};
                nbytes_next = NB_Y16;
            end
            default:
            begin
                word_next   = {8'd0, in_res.b, in_res.g, in_res.r};
                nbytes_next = NB_RGB;
            end
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg   <= word_next;
            nbytes_reg <= nbytes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_bytes = nbytes_reg;

endmodule

// ===== sim/tb_pixel_format_converter_unit.sv =====
// testbench for pixel_format_converter_unit: streams raw pixels through the converter
// under random source and output settings and checks every packed pixel against a predictor
// depends on pfc_pkg, pfc_if and the converter rtl

module tb_pixel_format_converter_unit;
    import pfc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_WAIT = 16;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_PIXELS = 95;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_PRINTED = 30;

    localparam logic [39:0] WEIGHT_R = 40'd19595;
    localparam logic [39:0] WEIGHT_G = 40'd38470;
    localparam logic [39:0] WEIGHT_B = 40'd7471;
    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
    localparam logic [3:0] LAST_CODE = 4'hF;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [NBYTES_W-1:0] nbytes;
    } packed_pixel_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pfc_in_if  pix_in_bus ();
    pfc_out_if pix_out_bus ();

    pixel_format_converter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus)
    );

    // predictor copy of the register settings
    logic [3:0] cfg_src;
    logic       cfg_be;
    logic [3:0] cfg_fmt;

    packed_pixel_t pending_pixels[$];
    bit no_idle;
    int pixels_sent;
    int pixels_checked;
    int settings_used;
    int mismatches;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_pixels.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic [15:0] sample16(input logic [63:0] px, input int c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = px[16*c +: 8];
        hi = px[16*c+8 +: 8];
        return cfg_be ? {lo, hi} : {hi, lo};
    endfunction

    function automatic logic [7:0] premultiply(input logic [7:0] a, input logic [7:0] c);
        logic [15:0] aa;
        logic [15:0] cc;
        logic [15:0] p;
        aa = a;
        cc = c;
        p = (aa * cc) / 16'd255;
        return p[7:0];
    endfunction

    function automatic packed_pixel_t convert_pixel(input logic [63:0] px);
        int ri;
        int gi;
        int bi;
        logic wide;
        logic has_alpha;
        logic [15:0] r16;
        logic [15:0] g16;
        logic [15:0] b16;
        logic [15:0] a16;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [39:0] luma;
        packed_pixel_t res;
        ri = 0;
        gi = 1;
        bi = 2;
        wide = 1'b0;
        has_alpha = 1'b0;
        case (cfg_src)
            SRC_BGR8:
            begin
                ri = 2;
                bi = 0;
            end
            SRC_MONO8:
            begin
                ri = 0;
                gi = 0;
                bi = 0;
            end
            SRC_MONO16:
            begin
                ri = 0;
                gi = 0;
                bi = 0;
                wide = 1'b1;
            end
            SRC_RGB16:  wide = 1'b1;
            SRC_BGR16:
            begin
                ri = 2;
                bi = 0;
                wide = 1'b1;
            end
            SRC_RGBA8:  has_alpha = 1'b1;
            SRC_BGRA8:
            begin
                ri = 2;
                bi = 0;
                has_alpha = 1'b1;
            end
            SRC_RGBA16:
            begin
                wide = 1'b1;
                has_alpha = 1'b1;
            end
            SRC_BGRA16:
            begin
                ri = 2;
                bi = 0;
                wide = 1'b1;
                has_alpha = 1'b1;
            end
            default:    ;
        endcase
        r16 = sample16(px, ri);
        g16 = sample16(px, gi);
        b16 = sample16(px, bi);
        a16 = has_alpha ? sample16(px, 3) : 16'hFFFF;
        if (wide)
        begin
            r = r16[15:8];
            g = g16[15:8];
            b = b16[15:8];
            a = a16[15:8];
        end
        else
        begin
            r = px[8*ri +: 8];
            g = px[8*gi +: 8];
            b = px[8*bi +: 8];
            a = has_alpha ? px[31:24] : OPAQUE_ALPHA;
        end
        case (cfg_fmt)
            FMT_BGR24:
            begin
                res.word = {8'd0, r, g, b};
                res.nbytes = NB_RGB;
            end
            FMT_RGB32:
            begin
                res.word = {OPAQUE_ALPHA, r, g, b};
                res.nbytes = NB_WORD;
            end
            FMT_BGR32:
            begin
                res.word = {OPAQUE_ALPHA, b, g, r};
                res.nbytes = NB_WORD;
            end
            FMT_ARGB32:
            begin
                res.word = {a, r, g, b};
                res.nbytes = NB_WORD;
            end
            FMT_BGRA32:
            begin
                res.word = {a, b, g, r};
                res.nbytes = NB_WORD;
            end
            FMT_ARGB32_PM:
            begin
                res.word = {a, premultiply(a, r), premultiply(a, g), premultiply(a, b)};
                res.nbytes = NB_WORD;
            end
            FMT_BGRA32_PM:
            begin
                res.word = {a, premultiply(a, b), premultiply(a, g), premultiply(a, r)};
                res.nbytes = NB_WORD;
            end
            FMT_Y8:
            begin
                luma = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
                res.word = {24'd0, luma[23:16]};
                res.nbytes = NB_Y8;
            end
            FMT_Y16:
            begin
                // 8-bit sources keep eight more fraction bits instead
                if (wide)
                begin
                    luma = WEIGHT_R * r16 + WEIGHT_G * g16 + WEIGHT_B * b16;
                    res.word = {16'd0, luma[31:16]};
                end
                else
                begin
                    luma = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
                    res.word = {16'd0, luma[23:8]};
                end
                res.nbytes = NB_Y16;
            end
            default:
            begin
                res.word = {8'd0, b, g, r};
                res.nbytes = NB_RGB;
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_pixel();
        logic [63:0] px;
        for (int k = 0; k < 8; k++)
        begin
            case ($urandom_range(3, 0))
                0:       px[8*k +: 8] = 8'h00;
                1:       px[8*k +: 8] = 8'hFF;
                default: px[8*k +: 8] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    function automatic int draw_wait();
        if (no_idle || $urandom_range(3, 0) == 0)
            return 0;
        return $urandom_range(MAX_WAIT, 0);
    endfunction

    // one request on pix_in; valid is left high after acceptance until the next request or stop_input drives it
    task automatic send_pixel(input logic [63:0] px);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            pix_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_bus.valid <= 1'b1;
        pix_in_bus.pixel_bytes <= px;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        pending_pixels.push_back(convert_pixel(px));
        pixels_sent++;
    endtask

    task automatic stop_input();
        pix_in_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // apb write followed directly by a read back of the same register
    task automatic config_register(input logic [1:0] idx, input logic [3:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SOURCE_ENCODING:   cfg_src = value;
            REG_SOURCE_BIG_ENDIAN: cfg_be = value[0];
            REG_OUTPUT_FORMAT:     cfg_fmt = value;
            default:               ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {28'd0, value})
            report_mismatch($sformatf("register %0d reads %h, written %h",
                                      idx, prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] src, input logic be, input logic [3:0] fmt);
        stop_input();
        drain_results();
        config_register(REG_SOURCE_ENCODING, src);
        config_register(REG_SOURCE_BIG_ENDIAN, {3'd0, be});
        config_register(REG_OUTPUT_FORMAT, fmt);
        settings_used++;
    endtask

    task automatic check_result(input logic [WORD_W-1:0] word, input logic [NBYTES_W-1:0] nbytes);
        packed_pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result %h/%0d with no request outstanding", word, nbytes));
        end
        else
        begin
            want = pending_pixels.pop_front();
            if (word !== want.word)
                report_mismatch($sformatf("out_word %h, expected %h (src %0d be %0d fmt %0d)",
                                          word, want.word, cfg_src, cfg_be, cfg_fmt));
            if (nbytes !== want.nbytes)
                report_mismatch($sformatf("out_bytes %0d, expected %0d (fmt %0d)",
                                          nbytes, want.nbytes, cfg_fmt));
        end
        pixels_checked++;
    endtask

    // receiver: random stall before each result, then take it and check it
    initial
    begin
        int stall;
        pix_out_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            repeat (stall)
            begin
                pix_out_bus.ready <= 1'b0;
                @(posedge clk);
            end
            pix_out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!pix_out_bus.valid)
                @(posedge clk);
            check_result(pix_out_bus.out_word, pix_out_bus.out_bytes);
        end
    end

    task automatic test_reset_defaults();
        send_pixel(64'h0);
        send_pixel({64{1'b1}});
        send_pixel(64'h0807_0605_0403_0201);
    endtask

    // half-transparent rgba pixel through every output format, plus an unused code
    task automatic test_output_formats();
        logic [3:0] fmt;
        for (int f = FMT_RGB24; f <= FMT_Y16; f++)
        begin
            fmt = 4'(f);
            set_config(SRC_RGBA8, 1'b0, fmt);
            send_pixel(64'h1234_5678_80C0_40FF);
        end
        set_config(SRC_RGBA8, 1'b0, LAST_CODE);
        send_pixel(64'h1234_5678_80C0_40FF);
    endtask

    task automatic test_source_encodings();
        logic [3:0] src;
        for (int s = SRC_RGB8; s <= SRC_BGRA16; s++)
        begin
            src = 4'(s);
            set_config(src, src[0], FMT_ARGB32);
            send_pixel(random_pixel());
        end
        set_config(SRC_BGRA16 + 4'd3, 1'b1, FMT_ARGB32);
        send_pixel(random_pixel());
    endtask

    // back-to-back burst, full pause until the pipeline empties, then a second burst
    task automatic test_drain_pause();
        set_config(SRC_RGBA16, 1'b1, FMT_Y16);
        no_idle = 1'b1;
        repeat (30)
            send_pixel(random_pixel());
        stop_input();
        drain_results();
        no_idle = 1'b0;
        repeat (30)
            send_pixel(random_pixel());
    endtask

    task automatic test_random_streams();
        logic [3:0] src;
        logic [3:0] fmt;
        logic be;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                src = SRC_RGB8;
                be = 1'b0;
                fmt = FMT_RGB24;
            end
            else if (phase == 1)
            begin
                src = LAST_CODE;
                be = 1'b1;
                fmt = LAST_CODE;
            end
            else
            begin
                src = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(LAST_CODE, SRC_BGRA16 + 1))
                                                 : 4'($urandom_range(SRC_BGRA16, SRC_RGB8));
                fmt = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(LAST_CODE, FMT_Y16 + 1))
                                                 : 4'($urandom_range(FMT_Y16, FMT_RGB24));
                be = 1'($urandom_range(1, 0));
            end
            set_config(src, be, fmt);
            no_idle = ($urandom_range(3, 0) == 0);
            repeat (PHASE_PIXELS)
                send_pixel(random_pixel());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in_bus.valid <= 1'b0;
        pix_in_bus.pixel_bytes <= '0;
        cfg_src = SRC_RGB8;
        cfg_be = 1'b0;
        cfg_fmt = FMT_RGB24;
        no_idle = 1'b0;
        pixels_sent = 0;
        pixels_checked = 0;
        settings_used = 0;
        mismatches = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_output_formats();
        test_source_encodings();
        test_drain_pause();
        test_random_streams();

        stop_input();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d pixels and checked %0d results over %0d register settings",
                 pixels_sent, pixels_checked, settings_used);
        $display("all source encodings and output formats, unused codes, %s; %0d mismatches",
                 "both byte orders", mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pfc_pkg.sv
rtl/pfc_if.sv
rtl/pfc_cfg.sv
rtl/pfc_unpack.sv
rtl/pfc_arith.sv
rtl/pfc_pack.sv
rtl/pixel_format_converter_unit.sv
sim/tb_pixel_format_converter_unit.sv
